// ===== hw/rtl/sevt_pkg.sv =====
// Shared types and constants for the sorted event table.
// Depends on nothing; used by sevt_ram users and sorted_event_table_unit.
package sevt_pkg;

	localparam int TABLE_DEPTH  = 64;
	localparam int TIME_BITS    = 48;
	localparam int PAYLOAD_BITS = 32;

	localparam int IDX_BITS = $clog2(TABLE_DEPTH);
	localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);

	localparam int IN_DATA_BITS  = ((TIME_BITS + PAYLOAD_BITS + 7) / 8) * 8;
	localparam int OUT_FLD_BITS  = 2 * TIME_BITS + PAYLOAD_BITS + CNT_BITS;
	localparam int OUT_DATA_BITS = ((OUT_FLD_BITS + 7) / 8) * 8;

	localparam logic [1:0] CMD_CLEAR    = 2'd0;
	localparam logic [1:0] CMD_INSERT   = 2'd1;
	localparam logic [1:0] CMD_QUERY    = 2'd2;
	localparam logic [1:0] CMD_DURATION = 2'd3;

	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_EMPTY   = 2'd1;
	localparam logic [1:0] STS_FULL    = 2'd2;
	localparam logic [1:0] STS_REFUSED = 2'd3;

	typedef struct packed {
		logic [PAYLOAD_BITS-1:0] slot_msg;
		logic [TIME_BITS-1:0]    slot_pos;
	} entry_t;

	localparam int ENTRY_BITS = $bits(entry_t);

endpackage

// ===== hw/rtl/sevt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sevt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/sorted_event_table_unit.sv =====
// Sorted event table: time-ordered event store with insert, query and duration control.
// Depends on sevt_pkg and sevt_ram.
//
// channel | dir | tuser           | tdata (low to high)
// s_*     | in  | command         | position, payload
// m_*     | out | status          | event_time, event_message, event_count, region_length
//
// One request at a time; s_tready is high while the sequencer is idle.
// Clear, refused insert, empty query and set-duration on an empty table go straight to the
// result; set-duration otherwise reads the last entry first. Insert moves entries up one
// at a time (at most TABLE_DEPTH - 1), through the one-read, one-write table RAM; query
// scans the stored entries, one entry per cycle.
// The result register lets a new request in while the previous result waits.
// Reset clears count, duration and handshake state; table contents need no clearing.
module sorted_event_table_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [1:0]                          s_tuser,  // command
	input  logic [sevt_pkg::IN_DATA_BITS-1:0]   s_tdata,  // position, payload, zero pad
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [1:0]                          m_tuser,  // status
	output logic [sevt_pkg::OUT_DATA_BITS-1:0]  m_tdata   // event_time, event_message,
	                                                      // event_count, region_length, zero pad
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INS  = 3'd1;
	localparam logic [2:0] ST_INS0 = 3'd2;
	localparam logic [2:0] ST_QRY  = 3'd3;
	localparam logic [2:0] ST_DUR  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]                           state_q;
	logic [sevt_pkg::CNT_BITS-1:0]        count_q;
	logic [sevt_pkg::TIME_BITS-1:0]       length_q;
	logic                                 m_tvalid_q;

	logic [sevt_pkg::TIME_BITS-1:0]       pos_q;
	logic [sevt_pkg::PAYLOAD_BITS-1:0]    pay_q;
	logic [sevt_pkg::IDX_BITS-1:0]        chk_q;
	logic [sevt_pkg::TIME_BITS-1:0]       best_q;
	logic [1:0]                           res_status_q;
	logic [sevt_pkg::TIME_BITS-1:0]       res_time_q;
	logic [sevt_pkg::PAYLOAD_BITS-1:0]    res_msg_q;

	logic [1:0]                           out_status_q;
	logic [sevt_pkg::TIME_BITS-1:0]       out_time_q;
	logic [sevt_pkg::PAYLOAD_BITS-1:0]    out_msg_q;
	logic [sevt_pkg::CNT_BITS-1:0]        out_cnt_q;
	logic [sevt_pkg::TIME_BITS-1:0]       out_len_q;

	logic [sevt_pkg::TIME_BITS-1:0]       in_pos;
	logic [sevt_pkg::PAYLOAD_BITS-1:0]    in_pay;
	logic                                 accept;
	logic                                 out_free;
	logic                                 table_full;
	logic                                 table_empty;
	logic [sevt_pkg::IDX_BITS-1:0]        last_idx;
	logic [sevt_pkg::IDX_BITS-1:0]        chk_inc;
	logic [sevt_pkg::IDX_BITS-1:0]        chk_dec;

	logic                                 ram_we;
	logic [sevt_pkg::IDX_BITS-1:0]        ram_waddr;
	sevt_pkg::entry_t                     ram_wdata;
	logic [sevt_pkg::IDX_BITS-1:0]        ram_raddr;
	sevt_pkg::entry_t                     ram_rdata;
	sevt_pkg::entry_t                     new_entry;

	logic                                 ins_move;
	logic                                 qry_better;
	logic [sevt_pkg::TIME_BITS-1:0]       qry_dist;
	logic                                 qry_last;

	assign in_pos = s_tdata[sevt_pkg::TIME_BITS-1:0];
	assign in_pay = s_tdata[sevt_pkg::TIME_BITS +: sevt_pkg::PAYLOAD_BITS];

	assign s_tready    = (state_q == ST_IDLE);
	assign accept      = s_tvalid && s_tready;
	assign out_free    = !m_tvalid_q || m_tready;
	assign table_full  = (count_q == sevt_pkg::CNT_BITS'(sevt_pkg::TABLE_DEPTH));
	assign table_empty = (count_q == '0);
	assign last_idx    = sevt_pkg::IDX_BITS'(count_q - 1'b1);
	assign chk_inc     = chk_q + sevt_pkg::IDX_BITS'(1);
	assign chk_dec     = chk_q - sevt_pkg::IDX_BITS'(1);

	assign new_entry.slot_pos = pos_q;
	assign new_entry.slot_msg = pay_q;

	assign ins_move   = (ram_rdata.slot_pos >= pos_q);
	assign qry_dist   = pos_q - ram_rdata.slot_pos;
	assign qry_better = (ram_rdata.slot_pos <= pos_q) && (qry_dist < best_q);
	assign qry_last   = (chk_q == last_idx);

	sevt_ram #(
		.WIDTH (sevt_pkg::ENTRY_BITS),
		.DEPTH (sevt_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = chk_inc;
		ram_wdata = ram_rdata;
		ram_raddr = chk_dec;
		unique case (state_q)
			ST_IDLE: begin
				ram_raddr = (s_tuser == sevt_pkg::CMD_QUERY) ? '0 : last_idx;
			end
			ST_INS: begin
				// move the entry up, or drop the new event into the gap above it
				ram_we = 1'b1;
				if (!ins_move) begin
					ram_wdata = new_entry;
				end
			end
			ST_INS0: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = new_entry;
			end
			ST_QRY: begin
				ram_raddr = chk_inc;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			length_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (s_tuser)
							sevt_pkg::CMD_CLEAR: begin
								count_q  <= '0;
								length_q <= '0;
								state_q  <= ST_DONE;
							end
							sevt_pkg::CMD_INSERT: begin
								if (table_full) begin
									state_q <= ST_DONE;
								end else begin
									count_q <= count_q + 1'b1;
									if (in_pos > length_q) begin
										length_q <= in_pos;
									end
									state_q <= table_empty ? ST_INS0 : ST_INS;
								end
							end
							sevt_pkg::CMD_QUERY: begin
								state_q <= table_empty ? ST_DONE : ST_QRY;
							end
							default: begin
								if (table_empty) begin
									length_q <= in_pos;
									state_q  <= ST_DONE;
								end else begin
									state_q <= ST_DUR;
								end
							end
						endcase
					end
				end
				ST_INS: begin
					if (!ins_move) begin
						state_q <= ST_DONE;
					end else if (chk_q == '0) begin
						state_q <= ST_INS0;
					end
				end
				ST_INS0: begin
					state_q <= ST_DONE;
				end
				ST_QRY: begin
					if (qry_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DUR: begin
					if (ram_rdata.slot_pos < pos_q) begin
						length_q <= pos_q;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					pos_q      <= in_pos;
					pay_q      <= in_pay;
					best_q     <= length_q;
					chk_q      <= (s_tuser == sevt_pkg::CMD_QUERY) ? '0 : last_idx;
					res_time_q <= '0;
					res_msg_q  <= '0;
					if (s_tuser == sevt_pkg::CMD_INSERT && table_full) begin
						res_status_q <= sevt_pkg::STS_FULL;
					end else if (s_tuser == sevt_pkg::CMD_QUERY && table_empty) begin
						res_status_q <= sevt_pkg::STS_EMPTY;
					end else begin
						res_status_q <= sevt_pkg::STS_OK;
					end
				end
			end
			ST_INS: begin
				chk_q <= chk_dec;
			end
			ST_QRY: begin
				chk_q <= chk_inc;
				if (qry_better) begin
					best_q     <= qry_dist;
					res_time_q <= ram_rdata.slot_pos;
					res_msg_q  <= ram_rdata.slot_msg;
				end else if (chk_q == '0) begin
					res_time_q <= ram_rdata.slot_pos;
					res_msg_q  <= ram_rdata.slot_msg;
				end
			end
			ST_DUR: begin
				if (!(ram_rdata.slot_pos < pos_q)) begin
					res_status_q <= sevt_pkg::STS_REFUSED;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_time_q   <= res_time_q;
					out_msg_q    <= res_msg_q;
					out_cnt_q    <= count_q;
					out_len_q    <= length_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = sevt_pkg::OUT_DATA_BITS'({out_len_q, out_cnt_q, out_msg_q, out_time_q});

endmodule
